// ----- design/ihex_pkg.sv -----
// Shared types and constants for the Intel HEX record parser.
// Depends on nothing; imported by the parser top level and the testbench.
`default_nettype none

package ihex_pkg;

  // Character position counter width and its saturation value.
  localparam int unsigned POS_W = 10;
  localparam logic [POS_W-1:0] POSITION_LIMIT = 10'd1023;

  // Fixed record field positions within a line.
  localparam logic [POS_W-1:0] POS_LEN_FIRST  = 10'd1;
  localparam logic [POS_W-1:0] POS_LEN_LAST   = 10'd2;
  localparam logic [POS_W-1:0] POS_OFS_FIRST  = 10'd3;
  localparam logic [POS_W-1:0] POS_OFS_LAST   = 10'd6;
  localparam logic [POS_W-1:0] POS_TYPE_FIRST = 10'd7;
  localparam logic [POS_W-1:0] POS_TYPE_LAST  = 10'd8;
  localparam logic [POS_W-1:0] DATA_START     = 10'd9;
  localparam logic [POS_W-1:0] POS_BASE_LAST  = 10'd12;

  // Opcodes of the command word.
  localparam logic OP_CHAR  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Result kinds.
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Record types that trigger an action.
  localparam logic [7:0] REC_DATA    = 8'h00;
  localparam logic [7:0] REC_EOF     = 8'h01;
  localparam logic [7:0] REC_EXT_LIN = 8'h04;

  localparam logic [1:0] EXT_COUNT_MAX = 2'd3;
  localparam logic [1:0] EXT_COUNT_ARM = 2'd2;

  typedef struct packed {
    logic       opcode;
    logic [7:0] character;
    logic       last_in_line;
  } cmd_t;

  typedef struct packed {
    logic        result_kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [7:0]  record_type;
    logic [15:0] total_len;
    logic [31:0] load_address;
    logic        end_seen;
    logic        ext_addr_valid;
  } res_t;

  // One queue entry holds everything one character produces: an optional
  // data byte and an optional record summary sharing the same snapshot.
  typedef struct packed {
    logic        has_data;
    logic        has_sum;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [7:0]  record_type;
    logic [15:0] total_len;
    logic [31:0] load_address;
    logic        end_seen;
    logic        ext_addr_valid;
  } entry_t;

endpackage

`default_nettype wire

// ----- design/intel_hex_record_parser.sv -----
// Intel HEX record parser top level: character decode, record state and
// a two-entry result queue. Depends on ihex_pkg.
`default_nettype none

// Usage:
// Command words arrive on cmd (cmd_valid/cmd_ready). A word is either one
// ASCII character of a record line, with last_in_line marking the line's
// final character, or a clear command that zeroes the running length, the
// byte index and the extended-address valid flag. Result words leave on res
// (res_valid/res_ready): a data word for every decoded byte of a type 0
// record, and a summary word on the last character of each line.
// The whole decode of a character is shallow logic that runs in the cycle
// the word is accepted; its results enter a two-entry queue and the first
// one is offered on res in the next cycle when the queue was empty.
// One command word per cycle is accepted while the queue is not full.
// A character that yields both a data byte and a summary leaves as two res
// words, so the queue output (one word per cycle) sets their long-run rate.
// cmd_ready depends only on the queue fill level, not on res_ready; while
// the receiver stalls the queue fills and cmd_ready drops when both entries
// are occupied. Synchronous reset clears all parser state and empties the
// queue.

module intel_hex_record_parser (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  output logic               cmd_ready,
  input  wire ihex_pkg::cmd_t cmd,
  output logic               res_valid,
  input  wire logic          res_ready,
  output ihex_pkg::res_t     res
);
  import ihex_pkg::*;

  // Parser state.
  logic [POS_W-1:0] char_position, char_position_next;
  logic             field_stopped, field_stopped_next;
  logic [3:0]       high_nibble, high_nibble_next;
  logic [7:0]       line_length, line_length_next;
  logic [7:0]       line_type, line_type_next;
  logic [15:0]      pending_offset, pending_offset_next;
  logic [15:0]      offset_address, offset_address_next;
  logic [15:0]      base_address, base_address_next;
  logic [15:0]      accumulated_length, accumulated_length_next;
  logic [15:0]      data_index, data_index_next;
  logic [1:0]       extended_count, extended_count_next;
  logic             extended_valid, extended_valid_next;
  logic             end_flag, end_flag_next;

  // Decode helpers.
  logic             cmd_fire, res_fire;
  logic             dig_hex;
  logic [3:0]       dig;
  logic             fs_eff;
  logic [7:0]       type_cur;
  logic             emit_data;
  logic [7:0]       data_val;
  logic [10:0]      data_end;
  entry_t           new_entry;
  logic             push;

  // Result queue.
  entry_t           queue [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count, count_next;
  logic             phase;
  logic             pop;
  entry_t           head;
  logic             head_both;

  assign cmd_fire = cmd_valid && cmd_ready;
  assign res_fire = res_valid && res_ready;

  // ASCII hex digit decode.
  always_comb begin
    dig_hex = 1'b0;
    dig     = 4'd0;
    if (cmd.character >= 8'h30 && cmd.character <= 8'h39) begin
      dig_hex = 1'b1;
      dig     = cmd.character[3:0];
    end else if ((cmd.character >= 8'h41 && cmd.character <= 8'h46) ||
                 (cmd.character >= 8'h61 && cmd.character <= 8'h66)) begin
      dig_hex = 1'b1;
      dig     = cmd.character[3:0] + 4'd9;
    end
  end

  // Last character position still inside the data bytes, plus one.
  assign data_end = 11'(DATA_START) + {2'b00, line_length, 1'b0};

  always_comb begin
    char_position_next      = char_position;
    field_stopped_next      = field_stopped;
    high_nibble_next        = high_nibble;
    line_length_next        = line_length;
    line_type_next          = line_type;
    pending_offset_next     = pending_offset;
    offset_address_next     = offset_address;
    base_address_next       = base_address;
    accumulated_length_next = accumulated_length;
    data_index_next         = data_index;
    extended_count_next     = extended_count;
    extended_valid_next     = extended_valid;
    end_flag_next           = end_flag;
    fs_eff                  = field_stopped;
    type_cur                = line_type;
    emit_data               = 1'b0;
    data_val                = 8'd0;

    if (cmd.opcode == OP_CLEAR) begin
      accumulated_length_next = 16'd0;
      data_index_next         = 16'd0;
      extended_valid_next     = 1'b0;
    end else begin
      if (char_position >= POS_LEN_FIRST && char_position <= POS_LEN_LAST) begin
        // Length field; its first position restarts the field.
        if (char_position == POS_LEN_FIRST) begin
          fs_eff           = 1'b0;
          line_length_next = 8'd0;
        end
        field_stopped_next = fs_eff;
        if (!fs_eff) begin
          if (dig_hex) begin
            line_length_next = {line_length_next[3:0], dig};
          end else begin
            field_stopped_next = 1'b1;
          end
        end
      end else if (char_position >= POS_OFS_FIRST && char_position <= POS_OFS_LAST) begin
        if (char_position == POS_OFS_FIRST) begin
          fs_eff              = 1'b0;
          pending_offset_next = 16'd0;
        end
        field_stopped_next = fs_eff;
        if (!fs_eff) begin
          if (dig_hex) begin
            pending_offset_next = {pending_offset_next[11:0], dig};
          end else begin
            field_stopped_next = 1'b1;
          end
        end
      end else if (char_position >= POS_TYPE_FIRST && char_position <= POS_TYPE_LAST) begin
        if (char_position == POS_TYPE_FIRST) begin
          fs_eff   = 1'b0;
          type_cur = 8'd0;
        end
        field_stopped_next = fs_eff;
        if (!fs_eff) begin
          if (dig_hex) begin
            type_cur = {type_cur[3:0], dig};
          end else begin
            field_stopped_next = 1'b1;
          end
        end
        line_type_next = type_cur;
        // The type is complete: take the record action.
        if (char_position == POS_TYPE_LAST) begin
          priority case (type_cur)
            REC_DATA: begin
              if (accumulated_length == 16'd0) begin
                offset_address_next = pending_offset;
              end
              accumulated_length_next = accumulated_length + {8'd0, line_length};
            end
            REC_EOF: begin
              end_flag_next = 1'b1;
            end
            REC_EXT_LIN: begin
              if (extended_count >= EXT_COUNT_ARM) begin
                extended_valid_next = 1'b1;
              end
              if (extended_count != EXT_COUNT_MAX) begin
                extended_count_next = extended_count + 2'd1;
              end
              base_address_next  = 16'd0;
              field_stopped_next = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end else if (char_position >= DATA_START) begin
        if (line_type == REC_DATA) begin
          if ({1'b0, char_position} < data_end) begin
            // DATA_START is odd, so odd positions hold a byte's high digit.
            if (char_position[0]) begin
              field_stopped_next = !dig_hex;
              high_nibble_next   = dig_hex ? dig : 4'd0;
            end else begin
              emit_data       = 1'b1;
              data_val        = (!field_stopped && dig_hex) ? {high_nibble, dig}
                                                            : {4'd0, high_nibble};
              data_index_next = data_index + 16'd1;
            end
          end
        end else if (line_type == REC_EXT_LIN && char_position <= POS_BASE_LAST) begin
          if (!field_stopped) begin
            if (dig_hex) begin
              base_address_next = {base_address[11:0], dig};
            end else begin
              field_stopped_next = 1'b1;
            end
          end
        end
      end

      if (char_position != POSITION_LIMIT) begin
        char_position_next = char_position + POS_W'(1);
      end

      if (cmd.last_in_line) begin
        char_position_next  = '0;
        line_length_next    = 8'd0;
        line_type_next      = 8'd0;
        pending_offset_next = 16'd0;
        high_nibble_next    = 4'd0;
        field_stopped_next  = 1'b0;
      end
    end
  end

  // Snapshot of the state as both results of this character see it.
  always_comb begin
    new_entry.has_data       = emit_data;
    new_entry.has_sum        = cmd.last_in_line;
    new_entry.data_byte      = data_val;
    new_entry.byte_index     = data_index;
    new_entry.record_type    = type_cur;
    new_entry.total_len      = accumulated_length_next;
    new_entry.load_address   = {base_address_next, offset_address_next};
    new_entry.end_seen       = end_flag_next;
    new_entry.ext_addr_valid = extended_valid_next;
  end

  assign push = cmd_fire && (cmd.opcode == OP_CHAR) && (emit_data || cmd.last_in_line);

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position      <= '0;
      field_stopped      <= 1'b0;
      high_nibble        <= 4'd0;
      line_length        <= 8'd0;
      line_type          <= 8'd0;
      pending_offset     <= 16'd0;
      offset_address     <= 16'd0;
      base_address       <= 16'd0;
      accumulated_length <= 16'd0;
      data_index         <= 16'd0;
      extended_count     <= 2'd0;
      extended_valid     <= 1'b0;
      end_flag           <= 1'b0;
    end else if (cmd_fire) begin
      char_position      <= char_position_next;
      field_stopped      <= field_stopped_next;
      high_nibble        <= high_nibble_next;
      line_length        <= line_length_next;
      line_type          <= line_type_next;
      pending_offset     <= pending_offset_next;
      offset_address     <= offset_address_next;
      base_address       <= base_address_next;
      accumulated_length <= accumulated_length_next;
      data_index         <= data_index_next;
      extended_count     <= extended_count_next;
      extended_valid     <= extended_valid_next;
      end_flag           <= end_flag_next;
    end
  end

  // Result queue. An entry with both a data byte and a summary is offered
  // twice; phase marks that its data word has already gone out.
  assign head      = queue[rd_ptr];
  assign head_both = head.has_data && head.has_sum;
  assign res_valid = (count != 2'd0);
  assign cmd_ready = (count != 2'd2);
  assign pop       = res_fire && (!head_both || phase);
  assign count_next = count + {1'b0, push} - {1'b0, pop};

  always_comb begin
    res.result_kind    = (head.has_data && !phase) ? KIND_DATA : KIND_SUMMARY;
    res.data_byte      = (res.result_kind == KIND_DATA) ? head.data_byte : 8'd0;
    // The summary reports the index after this character's data byte.
    res.byte_index     = (res.result_kind == KIND_SUMMARY && head.has_data)
                         ? head.byte_index + 16'd1 : head.byte_index;
    res.record_type    = head.record_type;
    res.total_len      = head.total_len;
    res.load_address   = head.load_address;
    res.end_seen       = head.end_seen;
    res.ext_addr_valid = head.ext_addr_valid;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
      phase  <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (res_fire) begin
        phase <= head_both && !phase;
      end
    end
  end

`ifndef SYNTHESIS
  // The queue never holds more than two entries.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result queue count out of range");

  // The second half of a double entry is a summary offered the next cycle.
  a_summary_follows: assert property (@(posedge clk) disable iff (rst)
    res_fire && head_both && !phase |=> res_valid && res.result_kind == KIND_SUMMARY)
    else $error("summary did not follow its data byte");

  // A line end always produces a result word.
  a_line_end_result: assert property (@(posedge clk) disable iff (rst)
    cmd_fire && cmd.opcode == OP_CHAR && cmd.last_in_line |=> res_valid)
    else $error("line end produced no result");

  // A clear command zeroes the running length and index.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd_fire && cmd.opcode == OP_CLEAR
    |=> accumulated_length == 16'd0 && data_index == 16'd0 && !extended_valid)
    else $error("clear did not zero the accumulators");

  // Phase is only set while the head entry carries both results.
  a_phase_head: assert property (@(posedge clk) disable iff (rst)
    phase |-> res_valid && head_both)
    else $error("phase set without a double entry at the head");
`endif

endmodule

`default_nettype wire

// ----- test/intel_hex_record_parser_test.sv -----
// Self-checking testbench for the Intel HEX record parser.
// Drives command words, predicts every result word and compares them;
// depends on ihex_pkg and intel_hex_record_parser.
`timescale 1ns / 1ps

module intel_hex_record_parser_test;
  import ihex_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_WORDS = 300;
  localparam int LONG_TAIL = 300;
  localparam logic [4:0] NOT_HEX = 5'd16;
  localparam logic [7:0] START_CODE = 8'h3A;

  typedef logic [7:0] char_q_t[$];
  typedef enum logic [1:0] {
    READY_ALWAYS, READY_MOSTLY, READY_RARELY, READY_PERIODIC
  } ready_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  cmd_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  res_t res;

  intel_hex_record_parser dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd(cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  always #6 clk = ~clk;

  // Parser state as the predictor sees it.
  logic [9:0]  pos_count = '0;
  logic        stop_flag = 1'b0;
  logic [3:0]  nibble_hi = '0;
  logic [7:0]  rec_length = '0;
  logic [7:0]  rec_type = '0;
  logic [15:0] ofs_pending = '0;
  logic [15:0] ofs_latched = '0;
  logic [15:0] base_hi = '0;
  logic [15:0] length_sum = '0;
  logic [15:0] byte_count = '0;
  logic [1:0]  ext_count = '0;
  logic        ext_valid = 1'b0;
  logic        eof_seen = 1'b0;

  res_t awaited_words[$];
  int   mismatch_count = 0;
  int   words_sent = 0;
  int   burst_left = 0;
  int   clear_pct = 0;
  int   idle_cycles = 0;

  ready_mode_e ready_mode = READY_ALWAYS;
  int          ready_left = 0;
  int unsigned cycle_count = 0;

  // Append one character at the end of a line under construction.
  function automatic void add_char(ref char_q_t q, input logic [7:0] c);
    q.insert(q.size(), c);
  endfunction

  // Append one predicted result word behind the older ones.
  function automatic void add_awaited(input res_t r);
    awaited_words.insert(awaited_words.size(), r);
  endfunction

  function automatic logic [4:0] hex_value(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 10);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 10);
    return NOT_HEX;
  endfunction

  // Shift one digit into a header field; the first digit of a field restarts it,
  // and the first non-hex character freezes it for the rest of the field.
  function automatic logic [15:0] next_field(logic [15:0] val, bit first, logic [4:0] d);
    if (first) begin
      stop_flag = 1'b0;
      val = '0;
    end
    if (!stop_flag) begin
      if (d != NOT_HEX) val = {val[11:0], d[3:0]};
      else stop_flag = 1'b1;
    end
    return val;
  endfunction

  function automatic res_t snapshot(logic kind, logic [7:0] data, logic [15:0] index);
    res_t r;
    r.result_kind = kind;
    r.data_byte = data;
    r.byte_index = index;
    r.record_type = rec_type;
    r.total_len = length_sum;
    r.load_address = {base_hi, ofs_latched};
    r.end_seen = eof_seen;
    r.ext_addr_valid = ext_valid;
    return r;
  endfunction

  // Advance the predicted parser by one accepted word and queue what it emits.
  task automatic parse_command(input cmd_t w);
    logic [4:0] d;
    int p;
    if (w.opcode == OP_CLEAR) begin
      length_sum = '0;
      byte_count = '0;
      ext_valid = 1'b0;
    end else begin
      d = hex_value(w.character);
      p = int'(pos_count);
      if (p >= POS_LEN_FIRST && p <= POS_LEN_LAST) begin
        rec_length = 8'(next_field(16'(rec_length), p == POS_LEN_FIRST, d));
      end else if (p >= POS_OFS_FIRST && p <= POS_OFS_LAST) begin
        ofs_pending = next_field(ofs_pending, p == POS_OFS_FIRST, d);
      end else if (p >= POS_TYPE_FIRST && p <= POS_TYPE_LAST) begin
        rec_type = 8'(next_field(16'(rec_type), p == POS_TYPE_FIRST, d));
        // The record action fires once the type field is complete.
        if (p == POS_TYPE_LAST) begin
          if (rec_type == REC_DATA) begin
            if (length_sum == 16'd0) ofs_latched = ofs_pending;
            length_sum = length_sum + 16'(rec_length);
          end else if (rec_type == REC_EOF) begin
            eof_seen = 1'b1;
          end else if (rec_type == REC_EXT_LIN) begin
            if (ext_count >= EXT_COUNT_ARM) ext_valid = 1'b1;
            if (ext_count < EXT_COUNT_MAX) ext_count = ext_count + 2'd1;
            base_hi = '0;
            stop_flag = 1'b0;
          end
        end
      end else if (p >= DATA_START) begin
        if (rec_type == REC_DATA) begin
          if (p < int'(DATA_START) + 2 * int'(rec_length)) begin
            if ((p - int'(DATA_START)) % 2 == 0) begin
              // First digit of a byte; a non-hex digit makes the byte zero.
              stop_flag = (d == NOT_HEX);
              nibble_hi = (d == NOT_HEX) ? 4'd0 : d[3:0];
            end else begin
              add_awaited(snapshot(KIND_DATA,
                  (!stop_flag && d != NOT_HEX) ? {nibble_hi, d[3:0]} : {4'd0, nibble_hi},
                  byte_count));
              byte_count = byte_count + 16'd1;
            end
          end
        end else if (rec_type == REC_EXT_LIN && p <= POS_BASE_LAST) begin
          if (!stop_flag) begin
            if (d != NOT_HEX) base_hi = {base_hi[11:0], d[3:0]};
            else stop_flag = 1'b1;
          end
        end
      end
      if (pos_count < POSITION_LIMIT) pos_count = pos_count + 10'd1;
      if (w.last_in_line) begin
        add_awaited(snapshot(KIND_SUMMARY, 8'd0, byte_count));
        pos_count = '0;
        rec_length = '0;
        rec_type = '0;
        ofs_pending = '0;
        nibble_hi = '0;
        stop_flag = 1'b0;
      end
    end
  endtask

  // Offer one word, hold it until accepted, then idle between bursts.
  task automatic send_word(input cmd_t w);
    int gap;
    cmd <= w;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_ready !== 1'b1);
    parse_command(w);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        cmd_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_clear();
    cmd_t w;
    w.opcode = OP_CLEAR;
    w.character = 8'($urandom_range(0, 255));
    w.last_in_line = 1'($urandom_range(0, 1));
    send_word(w);
  endtask

  // Send a line of characters; the final one carries last_in_line.
  task automatic send_line(input char_q_t line);
    cmd_t w;
    foreach (line[i]) begin
      if (clear_pct > 0 && $urandom_range(0, 99) < clear_pct) send_clear();
      w.opcode = OP_CHAR;
      w.character = line[i];
      w.last_in_line = (i == line.size() - 1);
      send_word(w);
    end
  endtask

  function automatic char_q_t text(string s);
    char_q_t q;
    for (int i = 0; i < s.len(); i++) add_char(q, s[i]);
    return q;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  function automatic void append_hex(ref char_q_t q, input logic [15:0] v, input int digits);
    for (int i = digits - 1; i >= 0; i--) add_char(q, hex_char(v[4*i +: 4]));
  endfunction

  // Build a record line with random offset, body and checksum digits, optionally
  // cut short after index cut and with some characters replaced by random bytes.
  task automatic send_record(input logic [7:0] kind, input logic [7:0] len,
                             input int nibbles, input int cut, input int noise_pct);
    char_q_t line;
    add_char(line, START_CODE);
    append_hex(line, 16'(len), 2);
    append_hex(line, 16'($urandom), 4);
    append_hex(line, 16'(kind), 2);
    for (int i = 0; i < nibbles; i++) add_char(line, hex_char(4'($urandom_range(0, 15))));
    append_hex(line, 16'($urandom), 2);
    if (cut >= 0 && cut < line.size() - 1) line = line[0:cut];
    foreach (line[i]) begin
      if ($urandom_range(0, 99) < noise_pct) line[i] = 8'($urandom_range(0, 255));
    end
    send_line(line);
  endtask

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Every accepted result word is held against the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (!rst && res_valid === 1'b1 && res_ready) begin
      if (awaited_words.size() == 0) begin
        report_mismatch("result word arrived with nothing expected");
      end else begin
        want = awaited_words.pop_front();
        check_field("result_kind", 32'(res.result_kind), 32'(want.result_kind));
        check_field("data_byte", 32'(res.data_byte), 32'(want.data_byte));
        check_field("byte_index", 32'(res.byte_index), 32'(want.byte_index));
        check_field("record_type", 32'(res.record_type), 32'(want.record_type));
        check_field("total_len", 32'(res.total_len), 32'(want.total_len));
        check_field("load_address", res.load_address, want.load_address);
        check_field("end_seen", 32'(res.end_seen), 32'(want.end_seen));
        check_field("ext_addr_valid", 32'(res.ext_addr_valid), 32'(want.ext_addr_valid));
      end
    end
  end

  // The receiver switches at random between stall patterns.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (ready_left == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      ready_left <= $urandom_range(20, 200);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS: res_ready <= 1'b1;
      READY_MOSTLY: res_ready <= ($urandom_range(0, 3) != 0);
      READY_RARELY: res_ready <= ($urandom_range(0, 3) == 0);
      default: res_ready <= (cycle_count[2:0] == 3'd0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && cmd_ready === 1'b1) || (res_valid === 1'b1 && res_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("Watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // A line holding only its start code still produces a summary.
  task automatic test_empty_line();
    send_line(text(":"));
  endtask

  // Three data bytes: a full byte, a byte whose first digit is not hex, and a
  // byte whose second digit is not hex. The offset FFFF latches on the empty sum.
  task automatic test_data_bytes();
    send_line(text(":03FFFF00aFG17x"));
  endtask

  // A clear word ignores its character and line end, then re-arms offset latching.
  task automatic test_clear_word();
    cmd_t w;
    w.opcode = OP_CLEAR;
    w.character = 8'hFF;
    w.last_in_line = 1'b1;
    send_word(w);
    send_line(text(":0112340000"));
    send_line(text(":0156780099"));
  endtask

  // Extended address records: valid from the third one on, cut base fields,
  // then a clear drops the flag until the next extended record.
  task automatic test_extended_address();
    send_line(text(":02000004ABCD"));
    send_line(text(":020000041"));
    send_line(text(":020000048zA1"));
    send_line(text(":02000004"));
    send_clear();
    send_line(text(":02000004fFfF"));
  endtask

  // End-of-file record with a NUL start code and an 0xFF checksum character.
  task automatic test_end_record();
    char_q_t line;
    line = text(":00000001FF");
    line[0] = 8'h00;
    line[9] = 8'hFF;
    send_line(line);
    send_line(text(":1"));
    send_line(text(":ABg"));
  endtask

  // A line that runs far past its fields; the extra characters are ignored.
  task automatic test_long_line();
    char_q_t line;
    line = text(":00000002");
    repeat (LONG_TAIL) add_char(line, 8'($urandom_range(0, 255)));
    send_line(line);
  endtask

  // Header-only data records of length FF add up in the running total.
  task automatic test_length_sum();
    send_clear();
    repeat (4) send_record(REC_DATA, 8'hFF, 0, 8, 0);
  endtask

  task automatic test_random_records();
    int start;
    int pick;
    int len;
    start = words_sent;
    clear_pct = 2;
    while (words_sent - start < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        send_clear();
      end else if (pick < 50) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
        send_record(REC_DATA, 8'(len),
                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2 * len + 6) : 2 * len,
                    -1, 3);
      end else if (pick < 64) begin
        send_record(REC_EXT_LIN, 8'h02, 4, -1, 3);
      end else if (pick < 68) begin
        send_record(REC_EOF, 8'h00, 0, -1, 3);
      end else if (pick < 76) begin
        send_record(8'($urandom_range(0, 255)), 8'($urandom_range(0, 4)),
                    $urandom_range(0, 8), -1, 3);
      end else if (pick < 90) begin
        send_record(($urandom_range(0, 1) == 0) ? REC_DATA : REC_EXT_LIN,
                    8'($urandom_range(0, 255)), $urandom_range(0, 20),
                    $urandom_range(0, 14), 10);
      end else begin
        send_record(8'($urandom), 8'($urandom), $urandom_range(0, 6),
                    $urandom_range(0, 14), 100);
      end
    end
    clear_pct = 0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_empty_line();
    test_data_bytes();
    test_clear_word();
    test_extended_address();
    test_end_record();
    test_long_line();
    test_length_sum();
    test_random_records();
    cmd_valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
